[rtl/fe_pkg.sv]
package fe_pkg;

  localparam int NSTG = 22;

  localparam logic [31:0] LOG2E = 32'h3FB8AA3B;
  localparam logic [31:0] LN2_HI = 32'h3F318000;
  localparam logic [31:0] LN2_LO = 32'hB95E8083;
  localparam logic [31:0] P0 = 32'h39506967;
  localparam logic [31:0] P1 = 32'h3AB743CE;
  localparam logic [31:0] P2 = 32'h3C088908;
  localparam logic [31:0] P3 = 32'h3D2AA9C1;
  localparam logic [31:0] P4 = 32'h3E2AAAAA;
  localparam logic [31:0] HALF = 32'h3F000000;
  localparam logic [31:0] ONE = 32'h3F800000;
  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam logic [31:0] PINF = 32'h7F800000;
  localparam logic [31:0] NINF = 32'hFF800000;
  localparam logic [30:0] LIM_MAG = 31'h42B00000;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_FLOOR,
    OP_SCALE
  } op_t;

  typedef enum logic [2:0] {
    SRC_X,
    SRC_KF,
    SRC_R,
    SRC_R2,
    SRC_ACC,
    SRC_CONST
  } src_t;

  typedef enum logic [1:0] {
    DST_ACC,
    DST_R,
    DST_R2,
    DST_KF
  } dst_t;

  typedef struct packed {
    op_t         op;
    src_t        sa;
    src_t        sb;
    logic [31:0] cst;
    dst_t        dst;
  } uop_t;

  typedef struct packed {
    logic              vld;
    logic              spc;
    logic [31:0]       spc_res;
    logic [31:0]       x;
    logic signed [8:0] k;
    logic [31:0]       kf;
    logic [31:0]       r;
    logic [31:0]       r2;
    logic [31:0]       acc;
  } pipe_t;

  function automatic uop_t uop_at(input int i);
    uop_t u;
    u = '{OP_MUL, SRC_ACC, SRC_R, 32'h0, DST_ACC};
    case (i)
      0: u = '{OP_MUL, SRC_X, SRC_CONST, LOG2E, DST_ACC};
      1: u = '{OP_ADD, SRC_ACC, SRC_CONST, HALF, DST_ACC};
      2: u = '{OP_FLOOR, SRC_ACC, SRC_ACC, 32'h0, DST_KF};
      3: u = '{OP_MUL, SRC_KF, SRC_CONST, LN2_HI, DST_ACC};
      4: u = '{OP_SUB, SRC_X, SRC_ACC, 32'h0, DST_R};
      5: u = '{OP_MUL, SRC_KF, SRC_CONST, LN2_LO, DST_ACC};
      6: u = '{OP_SUB, SRC_R, SRC_ACC, 32'h0, DST_R};
      7: u = '{OP_MUL, SRC_R, SRC_R, 32'h0, DST_R2};
      8: u = '{OP_MUL, SRC_CONST, SRC_R, P0, DST_ACC};
      9: u = '{OP_ADD, SRC_ACC, SRC_CONST, P1, DST_ACC};
      10: u = '{OP_MUL, SRC_ACC, SRC_R, 32'h0, DST_ACC};
      11: u = '{OP_ADD, SRC_ACC, SRC_CONST, P2, DST_ACC};
      12: u = '{OP_MUL, SRC_ACC, SRC_R, 32'h0, DST_ACC};
      13: u = '{OP_ADD, SRC_ACC, SRC_CONST, P3, DST_ACC};
      14: u = '{OP_MUL, SRC_ACC, SRC_R, 32'h0, DST_ACC};
      15: u = '{OP_ADD, SRC_ACC, SRC_CONST, P4, DST_ACC};
      16: u = '{OP_MUL, SRC_ACC, SRC_R, 32'h0, DST_ACC};
      17: u = '{OP_ADD, SRC_ACC, SRC_CONST, HALF, DST_ACC};
      18: u = '{OP_MUL, SRC_ACC, SRC_R2, 32'h0, DST_ACC};
      19: u = '{OP_ADD, SRC_ACC, SRC_R, 32'h0, DST_ACC};
      20: u = '{OP_ADD, SRC_ACC, SRC_CONST, ONE, DST_ACC};
      21: u = '{OP_SCALE, SRC_ACC, SRC_ACC, 32'h0, DST_ACC};
      default: u = '{OP_MUL, SRC_ACC, SRC_R, 32'h0, DST_ACC};
    endcase
    return u;
  endfunction

  function automatic logic [31:0] pick(input src_t s, input pipe_t p,
                                       input logic [31:0] c);
    logic [31:0] v;
    case (s)
      SRC_X: v = p.x;
      SRC_KF: v = p.kf;
      SRC_R: v = p.r;
      SRC_R2: v = p.r2;
      SRC_ACC: v = p.acc;
      SRC_CONST: v = c;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[rtl/fe_fmul.sv]
module fe_fmul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic               sgn;
  logic [47:0]        prod;
  logic [22:0]        m;
  logic               g;
  logic               s;
  logic [23:0]        mr;
  logic signed [10:0] e;
  logic               tiny_up;

  always_comb begin
    sgn = a[31] ^ b[31];
    prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    if (prod[47]) begin
      m = prod[46:24];
      g = prod[23];
      s = |prod[22:0];
    end else begin
      m = prod[45:23];
      g = prod[22];
      s = |prod[21:0];
    end
    e = $signed({3'b0, a[30:23]}) + $signed({3'b0, b[30:23]}) - 11'sd127
        + $signed({10'b0, prod[47]});
    tiny_up = (e == 11'sd0) && (&m);
    mr = {1'b0, m} + {23'b0, g & (s | m[0])};
    if (mr[23]) begin
      e = e + 11'sd1;
    end
    if (a[30:23] == 8'h00 || b[30:23] == 8'h00) begin
      y = {sgn, 31'h0};
    end else if (tiny_up) begin
      y = {sgn, 8'h01, 23'h0};
    end else if (e <= 11'sd0) begin
      y = {sgn, 31'h0};
    end else if (e >= 11'sd255) begin
      y = {sgn, 8'hFF, 23'h0};
    end else begin
      y = {sgn, e[7:0], mr[22:0]};
    end
  end

endmodule

[rtl/fe_fadd.sv]
module fe_fadd (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic               swp;
  logic [31:0]        big;
  logic [31:0]        sml;
  logic [7:0]         d;
  logic [26:0]        mb;
  logic [26:0]        ms;
  logic [53:0]        tmp;
  logic [26:0]        sh;
  logic [27:0]        sum;
  logic [26:0]        n;
  logic [4:0]         lz;
  logic               found;
  logic [23:0]        mr;
  logic signed [10:0] e;

  always_comb begin
    swp = b[30:0] > a[30:0];
    big = swp ? b : a;
    sml = swp ? a : b;
    d = big[30:23] - sml[30:23];
    mb = {1'b1, big[22:0], 3'b000};
    ms = {1'b1, sml[22:0], 3'b000};
    tmp = {ms, 27'h0} >> d;
    if (d >= 8'd27) begin
      sh = 27'h1;
    end else begin
      sh = {tmp[53:28], tmp[27] | (|tmp[26:0])};
    end
    if (big[31] == sml[31]) begin
      sum = {1'b0, mb} + {1'b0, sh};
    end else begin
      sum = {1'b0, mb} - {1'b0, sh};
    end
    lz = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && sum[i]) begin
        lz = 5'(26 - i);
        found = 1'b1;
      end
    end
    if (sum[27]) begin
      n = {sum[27:2], sum[1] | sum[0]};
      e = $signed({3'b0, big[30:23]}) + 11'sd1;
    end else begin
      n = sum[26:0] << lz;
      e = $signed({3'b0, big[30:23]}) - $signed({6'b0, lz});
    end
    mr = {1'b0, n[25:3]} + {23'b0, n[2] & ((n[1] | n[0]) | n[3])};
    if (mr[23]) begin
      e = e + 11'sd1;
    end
    if (a[30:23] == 8'h00 && b[30:23] == 8'h00) begin
      y = {a[31] & b[31], 31'h0};
    end else if (a[30:23] == 8'h00) begin
      y = b;
    end else if (b[30:23] == 8'h00) begin
      y = a;
    end else if (sum == 28'h0) begin
      y = 32'h0;
    end else if (e <= 11'sd0) begin
      y = {big[31], 31'h0};
    end else if (e >= 11'sd255) begin
      y = {big[31], 8'hFF, 23'h0};
    end else begin
      y = {big[31], e[7:0], mr[22:0]};
    end
  end

endmodule

[rtl/fe_stage.sv]
module fe_stage #(
  parameter int STG = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  fe_pkg::pipe_t din,
  output fe_pkg::pipe_t dout
);

  localparam fe_pkg::uop_t U = fe_pkg::uop_at(STG);

  logic [31:0]       opa;
  logic [31:0]       opb;
  logic [31:0]       fu_res;
  logic signed [8:0] fu_k;
  fe_pkg::pipe_t     nxt;
  fe_pkg::pipe_t     q;
  logic              q_vld;

  function automatic logic signed [8:0] floor_k(input logic [31:0] z);
    logic [7:0]  sh;
    logic [47:0] t;
    logic [8:0]  ip;
    logic        fr;
    logic [8:0]  k;
    if (z[30:23] < 8'd127) begin
      k = (z[31] && z[30:0] != 31'h0) ? 9'h1FF : 9'h000;
    end else begin
      sh = (z[30:23] >= 8'd150) ? 8'd0 : 8'd150 - z[30:23];
      t = {1'b1, z[22:0], 24'h0} >> sh;
      ip = t[32:24];
      fr = |t[23:0];
      k = z[31] ? 9'(-(ip + {8'h0, fr})) : ip;
    end
    return $signed(k);
  endfunction

  function automatic logic [31:0] int_to_f(input logic signed [8:0] k);
    logic [8:0]  mag;
    logic [3:0]  p;
    logic [31:0] t;
    mag = k[8] ? 9'(-k) : k;
    p = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (mag[i]) begin
        p = 4'(i);
      end
    end
    t = {23'h0, mag} << (5'd23 - {1'b0, p});
    if (mag == 9'h0) begin
      return 32'h0;
    end
    return {k[8], 8'd127 + {4'h0, p}, t[22:0]};
  endfunction

  function automatic logic [31:0] scale(input logic [31:0] yv,
                                        input logic signed [8:0] k);
    logic signed [10:0] e;
    e = $signed({3'b0, yv[30:23]}) + 11'(k);
    if (yv[30:0] == 31'h0) begin
      return yv;
    end
    if (e <= 11'sd0) begin
      return 32'h0;
    end
    if (e >= 11'sd255) begin
      return yv[31] ? fe_pkg::NINF : fe_pkg::PINF;
    end
    return {yv[31], e[7:0], yv[22:0]};
  endfunction

  assign opa = fe_pkg::pick(U.sa, din, U.cst);
  assign opb = fe_pkg::pick(U.sb, din, U.cst);

  generate
    if (U.op == fe_pkg::OP_MUL) begin : g_mul
      fe_fmul u_mul (.a(opa), .b(opb), .y(fu_res));
      assign fu_k = din.k;
    end else if (U.op == fe_pkg::OP_ADD) begin : g_add
      fe_fadd u_add (.a(opa), .b(opb), .y(fu_res));
      assign fu_k = din.k;
    end else if (U.op == fe_pkg::OP_SUB) begin : g_sub
      fe_fadd u_add (.a(opa), .b({~opb[31], opb[30:0]}), .y(fu_res));
      assign fu_k = din.k;
    end else if (U.op == fe_pkg::OP_FLOOR) begin : g_floor
      assign fu_k = floor_k(opa);
      assign fu_res = int_to_f(fu_k);
    end else begin : g_scale
      assign fu_k = din.k;
      assign fu_res = din.spc ? din.spc_res : scale(opa, din.k);
    end
  endgenerate

  always_comb begin
    nxt = din;
    nxt.k = fu_k;
    case (U.dst)
      fe_pkg::DST_ACC: nxt.acc = fu_res;
      fe_pkg::DST_R: nxt.r = fu_res;
      fe_pkg::DST_R2: nxt.r2 = fu_res;
      fe_pkg::DST_KF: nxt.kf = fu_res;
      default: nxt.acc = fu_res;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= din.vld;
    end
  end

  always_comb begin
    dout = q;
    dout.vld = q_vld;
  end

endmodule

[rtl/fp32_exp_unit.sv]
// Single-precision exp(x), one request per cycle, result taken from the last register stage.
// Each of the 22 register stages holds one rounded multiply or add (or the floor and
// final exponent scaling). busy stays low and done pulses for one cycle with result_bits;
// results cannot be held off.
module fp32_exp_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits,
  output logic        done,
  output logic [31:0] result_bits
);

  fe_pkg::pipe_t stg [fe_pkg::NSTG+1];
  logic [31:0]   xf;
  logic          is_nan;

  assign busy = 1'b0;
  assign xf = (x_bits[30:23] == 8'h00) ? {x_bits[31], 31'h0} : x_bits;
  assign is_nan = x_bits[30:23] == 8'hFF && x_bits[22:0] != 23'h0;

  always_comb begin
    stg[0] = '0;
    stg[0].vld = start && !busy;
    stg[0].x = xf;
    stg[0].spc = is_nan || xf[30:0] > fe_pkg::LIM_MAG;
    if (is_nan) begin
      stg[0].spc_res = fe_pkg::QNAN;
    end else if (!xf[31]) begin
      stg[0].spc_res = fe_pkg::PINF;
    end else begin
      stg[0].spc_res = 32'h0;
    end
  end

  generate
    for (genvar i = 0; i < fe_pkg::NSTG; i++) begin : g_stg
      fe_stage #(.STG(i)) u_stage (
        .clk (clk),
        .rst (rst),
        .din (stg[i]),
        .dout(stg[i+1])
      );
    end
  endgenerate

  assign done = stg[fe_pkg::NSTG].vld;
  assign result_bits = stg[fe_pkg::NSTG].acc;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, fe_pkg::NSTG))
    else $error("result without matching request");

  a_nan: assert property (@(posedge clk) disable iff (rst)
    (done && $past(x_bits[30:23] == 8'hFF && x_bits[22:0] != 23'h0, fe_pkg::NSTG))
    |-> result_bits == fe_pkg::QNAN)
    else $error("NaN request gave wrong result");

  a_canon: assert property (@(posedge clk) disable iff (rst)
    (done && result_bits[30:23] == 8'hFF)
    |-> (result_bits[22:0] == 23'h0 || result_bits == fe_pkg::QNAN))
    else $error("non-canonical NaN on result");
`endif

endmodule
